[sv/range_add_difference_array_defines.svh]
// Assertion macros for the difference-array engine.
// Both sample on clk_i and are switched off while rst_ni is low.
`ifndef RANGE_ADD_DIFFERENCE_ARRAY_DEFINES_SVH
`define RANGE_ADD_DIFFERENCE_ARRAY_DEFINES_SVH

// Same-cycle implication
`define RADA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rada: check failed");

// Next-cycle implication
`define RADA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rada: check failed");

`endif

[sv/rada_pkg.sv]
`default_nettype none
package rada_pkg;

  // Field widths fixed by the item format
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 2;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Request from the sequencer to the store
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage
`default_nettype wire

[sv/rada_mem.sv]
`default_nettype none
module rada_mem #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                            clk_i,
  input  rada_pkg::mem_req_t              req_i,
  output logic [rada_pkg::DATA_W-1:0]     rdata_o
);
  import rada_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // One write port, one read port, registered read data
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[sv/rada_seq.sv]
`default_nettype none
module rada_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [rada_pkg::FUNC_W-1:0]       func_i,
  input  logic [rada_pkg::IDX_W-1:0]        start_index_i,
  input  logic [rada_pkg::IDX_W-1:0]        end_index_i,
  input  logic signed [rada_pkg::DATA_W-1:0] operand_value_i,
  input  logic [rada_pkg::LEN_W-1:0]        len_i,
  output rada_pkg::mem_req_t                req_o,
  input  logic [rada_pkg::DATA_W-1:0]       rdata_i,
  output logic                              result_valid_o,
  output logic [rada_pkg::IDX_W-1:0]        out_index_o,
  output logic signed [rada_pkg::DATA_W-1:0] out_value_o,
  output logic                              last_flag_o,
  output logic                              status_o
);
  import rada_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD_LO,
    ST_ADD_HI,
    ST_READ
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  s_q;
  logic [IDX_W-1:0]  e_q;
  logic [DATA_W-1:0] v_q;
  logic              end_upd_q;
  logic [DATA_W-1:0] prev_q;
  logic [IDX_W-1:0]  cnt_q;
  logic              valid_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DATA_W-1:0] val_q;
  logic              last_q;
  logic              status_q;

  logic              accept;
  logic              load_ok;
  logic              range_ok;
  logic              end_upd;
  logic [IDX_W-1:0]  e_next;
  logic [DATA_W-1:0] sum;
  logic              cnt_last;

  assign accept = start_i && (state_q == ST_IDLE);

  // Index checks against the effective length
  assign load_ok  = {1'b0, start_index_i} < len_i;
  assign range_ok = ({1'b0, start_index_i} < len_i) && ({1'b0, end_index_i} < len_i) &&
                    (start_index_i <= end_index_i);
  assign end_upd  = ({1'b0, end_index_i} + LEN_W'(1)) < len_i;
  assign e_next   = e_q + IDX_W'(1);

  // Readout accumulator and end-of-run test
  assign sum      = val_q + rdata_i;
  assign cnt_last = ({1'b0, cnt_q} + LEN_W'(1)) == len_i;

  // Store requests
  always_comb begin
    req_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_LOAD && load_ok) begin
            req_o.we    = 1'b1;
            req_o.waddr = start_index_i;
            req_o.wdata = (start_index_i == '0) ? operand_value_i
                                                : operand_value_i - prev_q;
          end else if (func_i == FUNC_ADD && range_ok) begin
            req_o.re    = 1'b1;
            req_o.raddr = start_index_i;
          end else if (func_i == FUNC_READ) begin
            req_o.re    = 1'b1;
            req_o.raddr = '0;
          end
        end
      end
      ST_ADD_LO: begin
        req_o.we    = 1'b1;
        req_o.waddr = s_q;
        req_o.wdata = rdata_i + v_q;
        req_o.re    = end_upd_q;
        req_o.raddr = e_next;
      end
      ST_ADD_HI: begin
        req_o.we    = 1'b1;
        req_o.waddr = e_next;
        req_o.wdata = rdata_i - v_q;
      end
      ST_READ: begin
        req_o.re    = 1'b1;
        req_o.raddr = cnt_q + IDX_W'(1);
      end
      default: req_o = '0;
    endcase
  end

  // Sequencer state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      s_q       <= '0;
      e_q       <= '0;
      v_q       <= '0;
      end_upd_q <= 1'b0;
      prev_q    <= '0;
      cnt_q     <= '0;
      valid_q   <= 1'b0;
      idx_q     <= '0;
      val_q     <= '0;
      last_q    <= 1'b0;
      status_q  <= STATUS_OK;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            s_q       <= start_index_i;
            e_q       <= end_index_i;
            v_q       <= operand_value_i;
            end_upd_q <= end_upd;
            unique case (func_i)
              FUNC_LOAD: begin
                if (load_ok) begin
                  prev_q <= operand_value_i;
                end else begin
                  valid_q  <= 1'b1;
                  idx_q    <= '0;
                  val_q    <= '0;
                  last_q   <= 1'b0;
                  status_q <= STATUS_ERR;
                end
              end
              FUNC_ADD: begin
                if (range_ok) begin
                  state_q <= ST_ADD_LO;
                end else begin
                  valid_q  <= 1'b1;
                  idx_q    <= '0;
                  val_q    <= '0;
                  last_q   <= 1'b0;
                  status_q <= STATUS_ERR;
                end
              end
              FUNC_READ: begin
                state_q <= ST_READ;
                cnt_q   <= '0;
                val_q   <= '0;
              end
              default: begin
                valid_q  <= 1'b1;
                idx_q    <= '0;
                val_q    <= '0;
                last_q   <= 1'b0;
                status_q <= STATUS_ERR;
              end
            endcase
          end
        end
        ST_ADD_LO: begin
          state_q <= end_upd_q ? ST_ADD_HI : ST_IDLE;
        end
        ST_ADD_HI: begin
          state_q <= ST_IDLE;
        end
        ST_READ: begin
          valid_q  <= 1'b1;
          idx_q    <= cnt_q;
          val_q    <= sum;
          last_q   <= cnt_last;
          status_q <= STATUS_OK;
          cnt_q    <= cnt_q + IDX_W'(1);
          if (cnt_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign out_index_o    = idx_q;
  assign out_value_o    = val_q;
  assign last_flag_o    = last_q;
  assign status_o       = status_q;

endmodule
`default_nettype wire

[sv/range_add_difference_array.sv]
`default_nettype none
// Difference-array engine with range add and prefix-sum readout.
// Items: start is taken at a clock edge when busy is low; func_i selects
// load (0), range add (1) or readout (2). Results come out on
// result_valid_o for one cycle each with out_index_o, out_value_o,
// last_flag_o and status_o; the receiver cannot hold them off.
// used_length is written through cfg_we_i/cfg_wdata_i, by the user only while idle
// (the block does not enforce this); 0 acts as 1 and values above DEPTH act as DEPTH.
// Sequence, set by the registered read of the store and its read-modify-write:
//   load: no result, busy stays low.
//   range add: ST_ADD_LO, then ST_ADD_HI unless the end update falls past the
//     used length.
//   readout: L results, one per cycle, from ST_READ; busy until the last is registered.
//   bad index or unknown func: one error result the cycle after accept.
// Reset clears the sequencer, the previous-load value and sets used_length
// to 64; the store is not cleared and must be loaded before it is read.
module range_add_difference_array #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [rada_pkg::FUNC_W-1:0]        func_i,
  input  logic [rada_pkg::IDX_W-1:0]         start_index_i,
  input  logic [rada_pkg::IDX_W-1:0]         end_index_i,
  input  logic signed [rada_pkg::DATA_W-1:0] operand_value_i,
  input  logic                               cfg_we_i,
  input  logic [rada_pkg::LEN_W-1:0]         cfg_wdata_i,
  output logic                               result_valid_o,
  output logic [rada_pkg::IDX_W-1:0]         out_index_o,
  output logic signed [rada_pkg::DATA_W-1:0] out_value_o,
  output logic                               last_flag_o,
  output logic                               status_o
);
  import rada_pkg::*;

  `include "range_add_difference_array_defines.svh"

  logic [LEN_W-1:0]  used_len_q;
  logic [LEN_W-1:0]  eff_len;
  mem_req_t          req;
  logic [DATA_W-1:0] rdata;

  // used_length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_len_q <= LEN_W'(64);
    end else if (cfg_we_i) begin
      used_len_q <= cfg_wdata_i;
    end
  end

  // Clamp to 1..DEPTH
  always_comb begin
    priority if (used_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (used_len_q > LEN_W'(DEPTH)) begin
      eff_len = LEN_W'(DEPTH);
    end else begin
      eff_len = used_len_q;
    end
  end

  rada_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .func_i          (func_i),
    .start_index_i   (start_index_i),
    .end_index_i     (end_index_i),
    .operand_value_i (operand_value_i),
    .len_i           (eff_len),
    .req_o           (req),
    .rdata_i         (rdata),
    .result_valid_o  (result_valid_o),
    .out_index_o     (out_index_o),
    .out_value_o     (out_value_o),
    .last_flag_o     (last_flag_o),
    .status_o        (status_o)
  );

  rada_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  // Checks
  `RADA_ASSERT_NEXT(a_read_goes_busy, start && !busy && func_i == FUNC_READ, busy)
  `RADA_ASSERT_NOW(a_last_is_ok, result_valid_o && last_flag_o, status_o == STATUS_OK)
  `RADA_ASSERT_NOW(a_err_when_idle, result_valid_o && status_o == STATUS_ERR, !busy)
  `RADA_ASSERT_NOW(a_mid_run_busy, result_valid_o && status_o == STATUS_OK && !last_flag_o, busy)
  `RADA_ASSERT_NOW(a_no_wr_rd_clash, req.we && req.re, req.waddr != req.raddr)

endmodule
`default_nettype wire

[test/testbench.sv]
module testbench;

  localparam logic [rada_pkg::FUNC_W-1:0] FUNC_BAD = 2'd3;
  localparam int unsigned ITEM_TARGET    = 300;
  localparam int unsigned CALM_AFTER     = 250;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // One expected result
  typedef struct packed {
    logic [5:0]  idx;
    logic [31:0] value;
    logic        is_last;
    logic        status;
  } entry_t;

  // Running copy of the difference store; works out and checks the results
  class range_sum_tracker;
    logic [31:0] diffs [64];
    logic [31:0] last_load;
    logic [6:0]  len_reg;
    entry_t      due_q[$];
    int unsigned faults;

    function new();
      foreach (diffs[i]) diffs[i] = '0;
      last_load = '0;
      len_reg   = 7'd64;
      faults    = 0;
    endfunction

    // 0 acts as 1, anything past the store depth as the depth
    static function int unsigned span_of(logic [6:0] r);
      if (r == 0) return 1;
      if (r > 64) return 64;
      return 32'(r);
    endfunction

    function void write_length(logic [6:0] r);
      len_reg = r;
    endfunction

    function int unsigned outstanding();
      return due_q.size();
    endfunction

    // Queue one expected result behind the others
    function void add_due(entry_t r);
      due_q.insert(due_q.size(), r);
    endfunction

    function void push_error();
      entry_t r;
      r.idx     = '0;
      r.value   = '0;
      r.is_last = 1'b0;
      r.status  = rada_pkg::STATUS_ERR;
      add_due(r);
    endfunction

    // Apply one accepted item
    function void note_item(logic [1:0] f, logic [5:0] s, logic [5:0] e, logic [31:0] v);
      int unsigned n;
      logic [31:0] acc;
      entry_t      r;
      n = span_of(len_reg);
      case (f)
        rada_pkg::FUNC_LOAD: begin
          if (s >= n) begin
            push_error();
          end else begin
            diffs[s]  = (s == 0) ? v : v - last_load;
            last_load = v;
          end
        end
        rada_pkg::FUNC_ADD: begin
          if (s >= n || e >= n || s > e) begin
            push_error();
          end else begin
            diffs[s] = diffs[s] + v;
            if (e + 1 < n) diffs[e + 1] = diffs[e + 1] - v;
          end
        end
        rada_pkg::FUNC_READ: begin
          acc = '0;
          for (int unsigned i = 0; i < n; i++) begin
            acc       = acc + diffs[i];
            r.idx     = 6'(i);
            r.value   = acc;
            r.is_last = (i + 1 == n);
            r.status  = rada_pkg::STATUS_OK;
            add_due(r);
          end
        end
        default: push_error();
      endcase
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      faults++;
    endfunction

    function void check_result(logic [5:0] idx, logic [31:0] value, logic is_last,
                               logic status);
      entry_t want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual index %0d value %h",
                 $time, idx, value);
        faults++;
        return;
      end
      want = due_q.pop_front();
      if (idx !== want.idx) flag("out_index", want.idx, idx);
      if (value !== want.value) flag("out_value", want.value, value);
      if (is_last !== want.is_last) flag("last_flag", want.is_last, is_last);
      if (status !== want.status) flag("status", want.status, status);
    endfunction
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic [rada_pkg::FUNC_W-1:0]        func_i = '0;
  logic [rada_pkg::IDX_W-1:0]         start_index_i = '0;
  logic [rada_pkg::IDX_W-1:0]         end_index_i = '0;
  logic signed [rada_pkg::DATA_W-1:0] operand_value_i = '0;
  logic                               cfg_we_i = 1'b0;
  logic [rada_pkg::LEN_W-1:0]         cfg_wdata_i = '0;
  logic                               result_valid_o;
  logic [rada_pkg::IDX_W-1:0]         out_index_o;
  logic signed [rada_pkg::DATA_W-1:0] out_value_o;
  logic                               last_flag_o;
  logic                               status_o;

  range_sum_tracker tracker;
  int unsigned      sent = 0;
  int unsigned      len_now = 64;
  logic [63:0]      filled = '0;
  int unsigned      quiet_cycles = 0;

  range_add_difference_array uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .start_index_i  (start_index_i),
    .end_index_i    (end_index_i),
    .operand_value_i(operand_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .out_index_o    (out_index_o),
    .out_value_o    (out_value_o),
    .last_flag_o    (last_flag_o),
    .status_o       (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Results are checked before the item taken at the same edge is applied
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o)
        tracker.check_result(out_index_o, out_value_o, last_flag_o, status_o);
      if (start && !busy)
        tracker.note_item(func_i, start_index_i, end_index_i, operand_value_i);
      if (cfg_we_i) tracker.write_length(cfg_wdata_i);
    end
  end

  // Watchdog: too long without any traffic
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [5:0] pick_index();
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [6:0] pick_length();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd64;
      4: return 7'd127;
      5: return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(1, 12));
    endcase
  endfunction

  // True when every entry a readout of n would touch has been loaded
  function automatic bit covered(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      if (!filled[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Present one item and hold it until taken
  task automatic send_item(input logic [1:0] f, input logic [5:0] s, input logic [5:0] e,
                           input logic [31:0] v);
    func_i          <= f;
    start_index_i   <= s;
    end_index_i     <= e;
    operand_value_i <= v;
    start           <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (f == rada_pkg::FUNC_LOAD && s < len_now) filled[s] = 1'b1;
    sent++;
  endtask

  task automatic pause_items(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_pause();
    if (sent < CALM_AFTER && $urandom_range(0, 7) == 0) pause_items($urandom_range(1, 19));
  endtask

  // Register write once everything has drained and the store has settled
  task automatic set_length(input logic [6:0] r);
    start <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_wdata_i <= r;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    len_now = range_sum_tracker::span_of(r);
  endtask

  // One item the block must reject
  task automatic send_broken(input int unsigned n);
    logic [5:0] s, e;
    case ($urandom_range(0, 3))
      0: begin
        if (n < 64) send_item(rada_pkg::FUNC_LOAD, 6'($urandom_range(n, 63)), pick_index(),
                              pick_value());
        else send_item(FUNC_BAD, pick_index(), pick_index(), pick_value());
      end
      1: begin
        e = 6'($urandom_range(0, 62));
        s = 6'($urandom_range(e + 1, 63));
        send_item(rada_pkg::FUNC_ADD, s, e, pick_value());
      end
      2: begin
        if (n < 64) send_item(rada_pkg::FUNC_ADD, pick_index(), 6'($urandom_range(n, 63)),
                              pick_value());
        else send_item(FUNC_BAD, pick_index(), pick_index(), pick_value());
      end
      default: send_item(FUNC_BAD, pick_index(), pick_index(), pick_value());
    endcase
  endtask

  // New length, a load pass where needed, a mix of work, then a readout
  task automatic run_phase(input logic [6:0] r);
    int unsigned n, ops, sel;
    logic [5:0]  s, e;
    set_length(r);
    n = len_now;
    if (!covered(n) || $urandom_range(0, 1) == 0) begin
      for (int unsigned k = 0; k < n; k++) begin
        maybe_pause();
        send_item(rada_pkg::FUNC_LOAD, 6'(k), pick_index(), pick_value());
      end
    end
    ops = $urandom_range(4, 16);
    repeat (ops) begin
      maybe_pause();
      sel = $urandom_range(0, 19);
      if (sel < 10) begin
        s = 6'($urandom_range(0, n - 1));
        e = 6'($urandom_range(s, n - 1));
        send_item(rada_pkg::FUNC_ADD, s, e, pick_value());
      end else if (sel < 13) begin
        send_item(rada_pkg::FUNC_LOAD, 6'($urandom_range(0, n - 1)), pick_index(),
                  pick_value());
      end else if (sel < 16) begin
        send_item(rada_pkg::FUNC_READ, pick_index(), pick_index(), pick_value());
      end else begin
        send_broken(n);
      end
    end
    maybe_pause();
    send_item(rada_pkg::FUNC_READ, pick_index(), pick_index(), pick_value());
  endtask

  initial begin
    tracker = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: short array, extreme values, all error kinds
    set_length(7'd4);
    send_item(rada_pkg::FUNC_LOAD, 6'd0, 6'd0, 32'h7FFF_FFFF);
    send_item(rada_pkg::FUNC_LOAD, 6'd1, 6'd63, 32'h8000_0000);
    send_item(rada_pkg::FUNC_LOAD, 6'd2, 6'd0, 32'hFFFF_FFFF);
    send_item(rada_pkg::FUNC_LOAD, 6'd3, 6'd0, 32'h0000_0000);
    send_item(rada_pkg::FUNC_READ, 6'd0, 6'd0, 32'h0);
    // range ending on the last entry: no subtraction past the end
    send_item(rada_pkg::FUNC_ADD, 6'd0, 6'd3, 32'h0000_0001);
    send_item(rada_pkg::FUNC_ADD, 6'd1, 6'd2, 32'h8000_0000);
    send_item(rada_pkg::FUNC_ADD, 6'd2, 6'd2, 32'hFFFF_FFFF);
    send_item(rada_pkg::FUNC_READ, 6'd63, 6'd63, 32'hFFFF_FFFF);
    send_item(rada_pkg::FUNC_LOAD, 6'd4, 6'd0, 32'h1234_5678);
    send_item(rada_pkg::FUNC_LOAD, 6'd63, 6'd63, 32'hFFFF_FFFF);
    send_item(rada_pkg::FUNC_ADD, 6'd2, 6'd1, 32'h0000_0005);
    send_item(rada_pkg::FUNC_ADD, 6'd0, 6'd4, 32'h0000_0005);
    send_item(rada_pkg::FUNC_ADD, 6'd63, 6'd63, 32'h0000_0005);
    send_item(FUNC_BAD, 6'h3F, 6'h3F, 32'hFFFF_FFFF);
    // loads out of order
    send_item(rada_pkg::FUNC_LOAD, 6'd2, 6'd0, 32'h0000_0005);
    send_item(rada_pkg::FUNC_LOAD, 6'd1, 6'd0, 32'h0000_0009);
    send_item(rada_pkg::FUNC_READ, 6'd0, 6'd0, 32'h0);
    // zero length behaves as one entry
    set_length(7'd0);
    send_item(rada_pkg::FUNC_READ, 6'd0, 6'd0, 32'h0);
    send_item(rada_pkg::FUNC_LOAD, 6'd1, 6'd0, 32'h0000_0001);
    send_item(rada_pkg::FUNC_ADD, 6'd0, 6'd0, 32'h0000_0003);
    send_item(rada_pkg::FUNC_READ, 6'd0, 6'd0, 32'h0);

    // Random: full length first (over-range register), then mixed lengths
    run_phase(7'd127);
    run_phase(7'd64);
    while (sent < ITEM_TARGET) run_phase(pick_length());

    start <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/rada_pkg.sv
sv/rada_mem.sv
sv/rada_seq.sv
sv/range_add_difference_array.sv
test/testbench.sv
